>>> src/psched_pkg.sv
// Shared types, codes and sizes of the priority round-robin task scheduler.
// Used by the channel interfaces, the queue cells, the queue chain and the top level.
package psched_pkg;

    localparam int MAX_TASKS = 16;
    localparam int LEVELS    = 8;
    localparam int TASK_W    = 4;
    localparam int LEVEL_W   = 3;
    localparam int RUN_W     = 5;
    localparam int SLICE_W   = 16;
    localparam int TIME_W    = 32;
    localparam int MS_W      = 10;
    localparam int CFG_W     = 16;

    localparam logic [RUN_W-1:0] IDLE_ID = RUN_W'(MAX_TASKS);

    localparam logic [2:0] REQ_MAKE_READY = 3'd0;
    localparam logic [2:0] REQ_WAIT       = 3'd1;
    localparam logic [2:0] REQ_STOP       = 3'd2;
    localparam logic [2:0] REQ_YIELD      = 3'd3;
    localparam logic [2:0] REQ_TICK       = 3'd4;
    localparam logic [2:0] REQ_SCHEDULE   = 3'd5;

    localparam logic CFG_MS_PER_TICK     = 1'b0;
    localparam logic CFG_IDLE_TIME_SLICE = 1'b1;

    // Chain operations.
    localparam logic [2:0] CH_HOLD   = 3'd0;
    localparam logic [2:0] CH_APPEND = 3'd1;
    localparam logic [2:0] CH_INSERT = 3'd2;
    localparam logic [2:0] CH_REMOVE = 3'd3;
    localparam logic [2:0] CH_POP    = 3'd4;

    // Cell next-value selects.
    localparam logic [1:0] SEL_HOLD  = 2'd0;
    localparam logic [1:0] SEL_LOAD  = 2'd1;
    localparam logic [1:0] SEL_LEFT  = 2'd2;
    localparam logic [1:0] SEL_RIGHT = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [TASK_W-1:0]  task_id;
        logic [LEVEL_W-1:0] task_priority_in;
        logic [SLICE_W-1:0] slice_ms;
        logic [SLICE_W-1:0] delay_ticks;
    } t_req;

    typedef struct packed {
        logic               status;
        logic               reschedule;
        logic [RUN_W-1:0]   running_task;
        logic [RUN_W-1:0]   woken_count;
    } t_rsp;

    typedef struct packed {
        logic               valid;
        logic [TASK_W-1:0]  task_id;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  key;
    } t_entry;

    typedef struct packed {
        logic [1:0]         sel;
        logic               by_task;
        logic [TASK_W-1:0]  task_id;
        logic [LEVEL_W-1:0] level;
    } t_cell_ctrl;

    typedef struct packed {
        logic valid;
        logic hit;
        logic gt;
    } t_cell_flags;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [SLICE_W-1:0] slice;
    } t_tdata;

    // Lowest set bit of the level map, that is the highest priority present.
    function automatic logic [LEVEL_W-1:0] lowest_set(input logic [LEVELS-1:0] map);
        logic [LEVEL_W-1:0] r;
        r = LEVEL_W'(LEVELS - 1);
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (map[i]) begin
                r = LEVEL_W'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> src/psched_req_if.sv
// Request channel of the task scheduler: valid, ready and one request word.
// Depends on psched_pkg for the payload type.
interface psched_req_if;
    logic             valid;
    logic             ready;
    psched_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/psched_rsp_if.sv
// Result channel of the task scheduler: valid, ready and one result word.
// Depends on psched_pkg for the payload type.
interface psched_rsp_if;
    logic             valid;
    logic             ready;
    psched_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/priority_round_robin_task_scheduler_core.sv
// Top level of the priority round-robin task scheduler.
// Depends on psched_pkg, psched_req_if, psched_rsp_if and psched_chain.
//
// The scheduler takes one request word at a time and returns one result word
// for each. Ready tasks sit in a row of sixteen cells in arrival order, so the
// oldest entry of a level is the head of that level's FIFO; waiting tasks sit
// in a second row kept sorted by wake time, with ties in arrival order. Each
// cell shifts to its neighbor when an entry is inserted or removed. Per-task
// priority and slice live in a small memory with a registered read port.
// Tick wakes the due tasks one by one, reading each one's priority from the
// memory before appending it to the ready row. A finished result waits while
// the previous result still holds the output register. A new request is
// accepted while the previous result still waits in the output register. The
// idle task is number 16. Configuration writes are taken at any time through
// i_cfg_we.
module priority_round_robin_task_scheduler_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    psched_req_if.sink                    i_req,
    psched_rsp_if.source                  o_rsp,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [psched_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_EXEC      = 4'd1;
    localparam logic [3:0] S_MR_APPEND = 4'd2;
    localparam logic [3:0] S_WAIT_INS  = 4'd3;
    localparam logic [3:0] S_WAKE_CHK  = 4'd4;
    localparam logic [3:0] S_WAKE_RD   = 4'd5;
    localparam logic [3:0] S_CHARGE    = 4'd6;
    localparam logic [3:0] S_SCHED_RD  = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;

    localparam int TW = psched_pkg::TASK_W;
    localparam int LW = psched_pkg::LEVEL_W;

    logic [3:0]                       r_state;
    psched_pkg::t_req                 r_req;
    logic [psched_pkg::RUN_W-1:0]     r_cur;
    logic [LW-1:0]                    r_cur_level;
    logic                             r_cur_ready;
    logic [psched_pkg::SLICE_W-1:0]   r_time_left;
    logic [psched_pkg::TIME_W-1:0]    r_tick;
    logic [psched_pkg::TIME_W-1:0]    r_wake;
    logic [psched_pkg::MS_W-1:0]      r_ms;
    logic [psched_pkg::SLICE_W-1:0]   r_idle;
    logic                             r_status;
    logic                             r_resched;
    logic [psched_pkg::RUN_W-1:0]     r_woken;
    logic [TW-1:0]                    r_next;
    logic [LW-1:0]                    r_next_level;
    logic [TW-1:0]                    r_wtask;
    psched_pkg::t_rsp                 r_out;
    logic                             r_out_valid;
    psched_pkg::t_tdata               r_mem [psched_pkg::MAX_TASKS];
    psched_pkg::t_tdata               r_rd;

    // Chain controls.
    logic [2:0]                       w_rq_op;
    logic                             w_rq_by_task;
    logic [LW-1:0]                    w_rq_level;
    psched_pkg::t_entry               w_rq_new;
    psched_pkg::t_entry               w_rq_head;
    logic [psched_pkg::LEVELS-1:0]    w_map;
    logic [TW-1:0]                    w_rq_sel;
    logic [2:0]                       w_wq_op;
    psched_pkg::t_entry               w_wq_new;
    psched_pkg::t_entry               w_wq_head;
    logic [psched_pkg::LEVELS-1:0]    w_wq_map;
    logic [TW-1:0]                    w_wq_sel;
    logic [TW-1:0]                    w_rd_addr;

    logic                             w_accept;
    logic                             w_is_cur;
    logic [LW-1:0]                    w_run_level;
    logic [LW-1:0]                    w_best;
    logic                             w_switch;
    logic                             w_due;
    logic                             w_out_free;

    assign w_accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_is_cur    = (r_cur == {1'b0, r_req.task_id});
    assign w_run_level = (r_cur == psched_pkg::IDLE_ID) ? LW'(psched_pkg::LEVELS - 1)
                                                        : r_cur_level;
    assign w_best      = psched_pkg::lowest_set(w_map);
    assign w_switch    = !r_cur_ready || (w_best < w_run_level)
                         || ((w_best == w_run_level) && (r_time_left == '0));
    assign w_due       = w_wq_head.valid && (w_wq_head.key <= r_tick);
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    // Which queue edits the current step performs.
    always_comb begin
        w_rq_op      = psched_pkg::CH_HOLD;
        w_rq_by_task = 1'b1;
        w_rq_level   = '0;
        w_rq_new     = '0;
        w_wq_op      = psched_pkg::CH_HOLD;
        w_wq_new     = '0;
        w_rd_addr    = w_wq_head.task_id;
        case (r_state)
            S_EXEC: begin
                if ((r_req.req_type == psched_pkg::REQ_MAKE_READY && !(w_is_cur && r_cur_ready))
                    || r_req.req_type == psched_pkg::REQ_WAIT
                    || r_req.req_type == psched_pkg::REQ_STOP) begin
                    w_rq_op = psched_pkg::CH_REMOVE;
                    w_wq_op = psched_pkg::CH_REMOVE;
                end else if (r_req.req_type == psched_pkg::REQ_SCHEDULE
                             && w_map != '0 && w_switch) begin
                    // Pop the oldest task of the best level.
                    w_rq_op      = psched_pkg::CH_REMOVE;
                    w_rq_by_task = 1'b0;
                    w_rq_level   = w_best;
                    w_rd_addr    = w_rq_sel;
                end
            end
            S_MR_APPEND: begin
                w_rq_op          = psched_pkg::CH_APPEND;
                w_rq_new.valid   = 1'b1;
                w_rq_new.task_id = r_req.task_id;
                w_rq_new.level   = r_req.task_priority_in;
            end
            S_WAIT_INS: begin
                w_wq_op          = psched_pkg::CH_INSERT;
                w_wq_new.valid   = 1'b1;
                w_wq_new.task_id = r_req.task_id;
                w_wq_new.key     = r_wake;
            end
            S_WAKE_CHK: begin
                if (w_due) begin
                    w_wq_op = psched_pkg::CH_POP;
                end
            end
            S_WAKE_RD: begin
                w_rq_op          = psched_pkg::CH_APPEND;
                w_rq_new.valid   = 1'b1;
                w_rq_new.task_id = r_wtask;
                w_rq_new.level   = r_rd.level;
            end
            S_SCHED_RD: begin
                // The displaced task goes to the back of its own level.
                if (r_cur_ready && r_cur != psched_pkg::IDLE_ID) begin
                    w_rq_op          = psched_pkg::CH_APPEND;
                    w_rq_new.valid   = 1'b1;
                    w_rq_new.task_id = r_cur[TW-1:0];
                    w_rq_new.level   = r_cur_level;
                end
            end
            default: begin
                w_rq_op = psched_pkg::CH_HOLD;
            end
        endcase
    end

    psched_chain u_ready (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_rq_op),
        .i_by_task  (w_rq_by_task),
        .i_task     (r_req.task_id),
        .i_level    (w_rq_level),
        .i_new      (w_rq_new),
        .o_head     (w_rq_head),
        .o_map      (w_map),
        .o_sel_task (w_rq_sel)
    );

    psched_chain u_wait (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_wq_op),
        .i_by_task  (1'b1),
        .i_task     (r_req.task_id),
        .i_level    (w_rq_head.level),
        .i_new      (w_wq_new),
        .o_head     (w_wq_head),
        .o_map      (w_wq_map),
        .o_sel_task (w_wq_sel)
    );

    // Task data memory: written on make ready, read into a register ahead of use.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && r_req.req_type == psched_pkg::REQ_MAKE_READY) begin
            r_mem[r_req.task_id] <= '{level: r_req.task_priority_in, slice: r_req.slice_ms};
        end
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms   <= psched_pkg::MS_W'(1);
            r_idle <= psched_pkg::SLICE_W'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                psched_pkg::CFG_MS_PER_TICK: r_ms <= i_cfg_data[psched_pkg::MS_W-1:0];
                default:                     r_idle <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= psched_pkg::IDLE_ID;
            r_cur_level <= LW'(psched_pkg::LEVELS - 1);
            r_cur_ready <= 1'b1;
            r_time_left <= psched_pkg::SLICE_W'(10);
            r_tick      <= '0;
            r_out_valid <= 1'b0;
            r_status    <= 1'b0;
            r_resched   <= 1'b0;
            r_woken     <= '0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req     <= i_req.data;
                        r_status  <= 1'b0;
                        r_resched <= 1'b0;
                        r_woken   <= '0;
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                    case (r_req.req_type)
                        psched_pkg::REQ_MAKE_READY: begin
                            if (w_is_cur) begin
                                r_cur_level <= r_req.task_priority_in;
                            end
                            if (w_is_cur && r_cur_ready) begin
                                r_resched <= 1'b1;
                            end else begin
                                if (w_is_cur) begin
                                    r_cur_ready <= 1'b0;
                                end
                                r_resched <= !r_cur_ready || w_is_cur
                                             || (r_req.task_priority_in < w_run_level);
                                r_state   <= S_MR_APPEND;
                            end
                        end
                        psched_pkg::REQ_WAIT: begin
                            if (w_is_cur) begin
                                r_cur_ready <= 1'b0;
                            end
                            r_wake    <= r_tick + {16'd0, r_req.delay_ticks};
                            r_resched <= 1'b1;
                            r_state   <= S_WAIT_INS;
                        end
                        psched_pkg::REQ_STOP: begin
                            if (w_is_cur) begin
                                r_cur_ready <= 1'b0;
                            end
                            r_resched <= 1'b1;
                        end
                        psched_pkg::REQ_YIELD: begin
                            if (w_is_cur) begin
                                r_time_left <= '0;
                                r_resched   <= 1'b1;
                            end else begin
                                r_status <= 1'b1;
                            end
                        end
                        psched_pkg::REQ_TICK: begin
                            r_tick  <= r_tick + 1'b1;
                            r_state <= S_WAKE_CHK;
                        end
                        psched_pkg::REQ_SCHEDULE: begin
                            if (w_map == '0) begin
                                if (!r_cur_ready) begin
                                    r_cur       <= psched_pkg::IDLE_ID;
                                    r_cur_level <= LW'(psched_pkg::LEVELS - 1);
                                    r_cur_ready <= 1'b1;
                                    r_time_left <= r_idle;
                                end
                            end else if (w_switch) begin
                                r_next       <= w_rq_sel;
                                r_next_level <= w_best;
                                r_state      <= S_SCHED_RD;
                            end
                        end
                        default: begin
                            r_status <= 1'b1;
                        end
                    endcase
                end
                S_MR_APPEND: begin
                    r_state <= S_DONE;
                end
                S_WAIT_INS: begin
                    r_state <= S_DONE;
                end
                S_WAKE_CHK: begin
                    if (w_due) begin
                        r_wtask <= w_wq_head.task_id;
                        r_state <= S_WAKE_RD;
                    end else begin
                        r_state <= S_CHARGE;
                    end
                end
                S_WAKE_RD: begin
                    if (r_rd.level < w_run_level) begin
                        r_resched <= 1'b1;
                    end
                    r_woken <= r_woken + 1'b1;
                    r_state <= S_WAKE_CHK;
                end
                S_CHARGE: begin
                    if (r_time_left > {6'd0, r_ms}) begin
                        r_time_left <= r_time_left - {6'd0, r_ms};
                    end else begin
                        r_time_left <= '0;
                        r_resched   <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_SCHED_RD: begin
                    r_cur       <= {1'b0, r_next};
                    r_cur_level <= r_next_level;
                    r_cur_ready <= 1'b1;
                    r_time_left <= r_rd.slice;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result word, loaded as the request finishes.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out.status       <= r_status;
            r_out.reschedule   <= r_resched;
            r_out.running_task <= r_cur;
            r_out.woken_count  <= r_woken;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

>>> src/psched_cell.sv
// One cell of a queue chain: holds one entry and takes a new one, its left
// or its right neighbor's entry. Depends on psched_pkg.
module psched_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  psched_pkg::t_cell_ctrl   i_ctrl,
    input  psched_pkg::t_entry       i_new,
    input  psched_pkg::t_entry       i_left,
    input  psched_pkg::t_entry       i_right,
    output psched_pkg::t_entry       o_entry,
    output psched_pkg::t_cell_flags  o_flags
);

    psched_pkg::t_entry r_entry;
    psched_pkg::t_entry n_entry;

    always_comb begin
        case (i_ctrl.sel)
            psched_pkg::SEL_LOAD:  n_entry = i_new;
            psched_pkg::SEL_LEFT:  n_entry = i_left;
            psched_pkg::SEL_RIGHT: n_entry = i_right;
            default:               n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.task_id <= n_entry.task_id;
        r_entry.level   <= n_entry.level;
        r_entry.key     <= n_entry.key;
    end

    assign o_entry       = r_entry;
    assign o_flags.valid = r_entry.valid;
    assign o_flags.hit   = r_entry.valid && (i_ctrl.by_task ? (r_entry.task_id == i_ctrl.task_id)
                                                            : (r_entry.level == i_ctrl.level));
    assign o_flags.gt    = r_entry.valid && (r_entry.key > i_new.key);

endmodule

>>> src/psched_chain.sv
// Row of queue cells with append, sorted insert, remove-first-match and pop.
// Depends on psched_pkg and psched_cell.
module psched_chain (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [2:0]                      i_op,
    input  logic                            i_by_task,
    input  logic [psched_pkg::TASK_W-1:0]   i_task,
    input  logic [psched_pkg::LEVEL_W-1:0]  i_level,
    input  psched_pkg::t_entry              i_new,
    output psched_pkg::t_entry              o_head,
    output logic [psched_pkg::LEVELS-1:0]   o_map,
    output logic [psched_pkg::TASK_W-1:0]   o_sel_task
);

    localparam int N = psched_pkg::MAX_TASKS;

    psched_pkg::t_entry      w_entry [N];
    psched_pkg::t_cell_flags w_flags [N];
    psched_pkg::t_cell_ctrl  w_ctrl  [N];
    psched_pkg::t_entry      w_empty;
    logic [N-1:0]            w_f;
    logic [N-1:0]            w_before;
    logic [N-1:0]            w_pos;
    logic                    w_grow;

    assign w_empty = '0;
    assign w_grow  = (i_op == psched_pkg::CH_APPEND) || (i_op == psched_pkg::CH_INSERT);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            case (i_op)
                psched_pkg::CH_APPEND: w_f[i] = !w_flags[i].valid;
                psched_pkg::CH_INSERT: w_f[i] = !w_flags[i].valid || w_flags[i].gt;
                psched_pkg::CH_REMOVE: w_f[i] = w_flags[i].hit;
                psched_pkg::CH_POP:    w_f[i] = (i == 0) && w_flags[i].valid;
                default:               w_f[i] = 1'b0;
            endcase
        end
        w_before[0] = 1'b0;
        for (int i = 1; i < N; i++) begin
            w_before[i] = w_before[i-1] | w_f[i-1];
        end
        w_pos = w_f & ~w_before;
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_ctrl[i].by_task = i_by_task;
            w_ctrl[i].task_id = i_task;
            w_ctrl[i].level   = i_level;
            if (w_grow) begin
                w_ctrl[i].sel = w_pos[i] ? psched_pkg::SEL_LOAD
                              : (w_before[i] ? psched_pkg::SEL_LEFT : psched_pkg::SEL_HOLD);
            end else begin
                w_ctrl[i].sel = (w_pos[i] || w_before[i]) ? psched_pkg::SEL_RIGHT
                                                          : psched_pkg::SEL_HOLD;
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        psched_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[g]),
            .i_new   (i_new),
            .i_left  ((g == 0) ? w_empty : w_entry[(g == 0) ? 0 : g-1]),
            .i_right ((g == N-1) ? w_empty : w_entry[(g == N-1) ? N-1 : g+1]),
            .o_entry (w_entry[g]),
            .o_flags (w_flags[g])
        );
    end

    always_comb begin
        o_map      = '0;
        o_sel_task = '0;
        for (int i = 0; i < N; i++) begin
            if (w_entry[i].valid) begin
                o_map[w_entry[i].level] = 1'b1;
            end
            if (w_pos[i]) begin
                o_sel_task = o_sel_task | w_entry[i].task_id;
            end
        end
    end

    assign o_head = w_entry[0];

endmodule

>>> src/psched_checker.sv
// Port-level checks of the task scheduler and the bind that attaches them.
// Depends on psched_pkg and the scheduler top level.
module psched_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input psched_pkg::t_rsp             i_rsp_data
);

    // No result survives a reset.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    // The running task is a real task or the idle task.
    a_running_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_data.running_task <= psched_pkg::IDLE_ID))
        else $error("running task out of range");

    // A tick cannot wake more tasks than exist.
    a_woken_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_data.woken_count <= 5'(psched_pkg::MAX_TASKS)))
        else $error("woken count out of range");

    // A stalled result holds its word.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled result changed");

endmodule

bind priority_round_robin_task_scheduler_core psched_checker u_psched_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
